[rtl/amst_pkg.sv]
package amst_pkg;

	localparam int SLOTS_DEF   = 10;
	localparam int MS_PER_S    = 1000;
	localparam int TIMEOUT_RST = 5;
	localparam int LIMIT_W     = 18;

	localparam logic [1:0] OP_SHOW  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] RC_NEW     = 2'd0;
	localparam logic [1:0] RC_REFRESH = 2'd1;
	localparam logic [1:0] RC_FULL    = 2'd2;
	localparam logic [1:0] RC_NONE    = 2'd3;

endpackage

[rtl/aging_message_slot_table.sv]
// Table of message slots with aging. One word in on the s_axis side gives one word out on
// the m_axis side. The operation travels in s_axis_tuser: show stores or refreshes an id,
// tick expires entries older than the timeout and compacts the survivors toward slot 0,
// clear empties the table, and read returns one slot. The user must write the timeout in
// seconds via timeout_we and timeout_wdata only while idle; the block does not enforce it.
// Show and tick walk the slots one per cycle through a single read port of the slot memory
// and one age subtract and compare, which only tick uses.
// The block takes a new word only when the previous one is finished. A finished result
// waits in the output register while the next word is already accepted; if the receiver
// still stalls when the next result is ready, the block holds that result and stays busy.
// Reset empties the table, sets the timeout to five seconds and drops any pending result.
module aging_message_slot_table #(
	parameter int SLOTS = amst_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // message_id[5:0], now_ms[37:6], slot_index[41:38]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // active_count[3:0], read_valid[4], read_message[10:5]
	output logic [1:0]  m_axis_tuser,  // result_code[1:0]
	input  logic        timeout_we,
	input  logic [7:0]  timeout_wdata
);

	localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PTR_W  = $clog2(SLOTS + 1);
	localparam int IW     = (SIDX_W > 4) ? SIDX_W : 4;
	localparam int CW     = (PTR_W > 4) ? PTR_W : 4;
	localparam int LW     = amst_pkg::LIMIT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_WRITE1 = 3'd2;
	localparam logic [2:0] ST_WRITE2 = 3'd3;
	localparam logic [2:0] ST_RD     = 3'd4;
	localparam logic [2:0] ST_RDWAIT = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [LW-1:0]     limit_q;
	logic [SLOTS-1:0]  occ_q;
	logic [PTR_W-1:0]  cnt_q;
	logic [1:0]        op_q;
	logic [5:0]        id_q;
	logic [31:0]       now_q;
	logic [3:0]        idx_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  dst_q;
	logic              free_found_q;
	logic              match_found_q;
	logic [SIDX_W-1:0] free_idx_q;
	logic [SIDX_W-1:0] match_idx_q;
	logic [1:0]        res_code_q;
	logic              res_rvalid_q;
	logic [5:0]        res_rmsg_q;
	logic              m_valid_q;
	logic [1:0]        m_code_q;
	logic [15:0]       m_data_q;

	logic [5:0]        msg_mem [SLOTS];
	logic [31:0]       stamp_mem [SLOTS];
	logic              rd_vld_s1;
	logic [SIDX_W-1:0] proc_idx_s1;
	logic [5:0]        rd_msg_s1;
	logic [31:0]       rd_stamp_s1;

	logic              accept;
	logic              out_free;
	logic              scan_more;
	logic              rd_en;
	logic [SIDX_W-1:0] rd_addr;
	logic [IW-1:0]     idx_ext;
	logic              idx_in_range;
	logic              proc_occ;
	logic [31:0]       age;
	logic              expired;
	logic              tick_proc;
	logic              tick_keep;
	logic              show_proc;
	logic              mem_we;
	logic [SIDX_W-1:0] mem_waddr;
	logic [5:0]        mem_wmsg;
	logic [31:0]       mem_wstamp;
	logic [SIDX_W-1:0] dst_idx;
	logic [CW-1:0]     cnt_ext;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign scan_more     = (ptr_q < PTR_W'(SLOTS));
	assign idx_ext       = IW'(idx_q);
	assign idx_in_range  = (32'(idx_q) < SLOTS);
	assign dst_idx       = dst_q[SIDX_W-1:0];
	assign cnt_ext       = CW'(cnt_q);

	assign proc_occ  = occ_q[proc_idx_s1];
	assign age       = now_q - rd_stamp_s1;
	assign expired   = age > 32'(limit_q);
	assign tick_proc = (state_q == ST_SCAN) && (op_q == amst_pkg::OP_TICK) && rd_vld_s1
		&& proc_occ;
	assign tick_keep = tick_proc && !expired;
	assign show_proc = (state_q == ST_SCAN) && (op_q == amst_pkg::OP_SHOW) && rd_vld_s1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[SIDX_W-1:0];
		if (state_q == ST_SCAN && scan_more) begin
			rd_en = 1'b1;
		end else if (state_q == ST_RD) begin
			rd_en   = 1'b1;
			rd_addr = idx_ext[SIDX_W-1:0];
		end
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = dst_idx;
		mem_wmsg   = rd_msg_s1;
		mem_wstamp = rd_stamp_s1;
		if (tick_keep) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WRITE1 && free_found_q) begin
			mem_we     = 1'b1;
			mem_waddr  = free_idx_q;
			mem_wmsg   = id_q;
			mem_wstamp = now_q;
		end else if (state_q == ST_WRITE2 && match_found_q) begin
			mem_we     = 1'b1;
			mem_waddr  = match_idx_q;
			mem_wmsg   = id_q;
			mem_wstamp = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			msg_mem[mem_waddr]   <= mem_wmsg;
			stamp_mem[mem_waddr] <= mem_wstamp;
		end
		if (rd_en) begin
			rd_msg_s1   <= msg_mem[rd_addr];
			rd_stamp_s1 <= stamp_mem[rd_addr];
			proc_idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LW'(amst_pkg::TIMEOUT_RST * amst_pkg::MS_PER_S);
		end else if (timeout_we) begin
			limit_q <= LW'(timeout_wdata * amst_pkg::MS_PER_S);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			occ_q         <= '0;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			ptr_q         <= '0;
			dst_q         <= '0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (m_valid_q && m_axis_tready && !(state_q == ST_DONE && out_free)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q          <= s_axis_tuser;
						id_q          <= s_axis_tdata[5:0];
						now_q         <= s_axis_tdata[37:6];
						idx_q         <= s_axis_tdata[41:38];
						ptr_q         <= '0;
						dst_q         <= '0;
						free_found_q  <= 1'b0;
						match_found_q <= 1'b0;
						res_code_q    <= amst_pkg::RC_NONE;
						res_rvalid_q  <= 1'b0;
						res_rmsg_q    <= '0;
						case (s_axis_tuser)
							amst_pkg::OP_SHOW,
							amst_pkg::OP_TICK: state_q <= ST_SCAN;
							amst_pkg::OP_CLEAR: begin
								occ_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_RD;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					if (show_proc) begin
						if (proc_occ && rd_msg_s1 == id_q && !match_found_q) begin
							match_found_q <= 1'b1;
							match_idx_q   <= proc_idx_s1;
						end
						if (!proc_occ && !free_found_q && !match_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= proc_idx_s1;
						end
					end
					if (tick_proc) begin
						if (expired || dst_idx != proc_idx_s1) begin
							occ_q[proc_idx_s1] <= 1'b0;
						end
						if (!expired) begin
							occ_q[dst_idx] <= 1'b1;
							dst_q          <= dst_q + PTR_W'(1);
						end
					end
					if (!scan_more && !rd_vld_s1) begin
						if (op_q == amst_pkg::OP_TICK) begin
							cnt_q   <= dst_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WRITE1;
						end
					end
				end
				ST_WRITE1: begin
					if (free_found_q) begin
						occ_q[free_idx_q] <= 1'b1;
						cnt_q             <= cnt_q + PTR_W'(1);
					end
					state_q <= ST_WRITE2;
				end
				ST_WRITE2: begin
					if (match_found_q) begin
						res_code_q <= amst_pkg::RC_REFRESH;
					end else if (free_found_q) begin
						res_code_q <= amst_pkg::RC_NEW;
					end else begin
						res_code_q <= amst_pkg::RC_FULL;
					end
					state_q <= ST_DONE;
				end
				ST_RD: begin
					state_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					if (idx_in_range && occ_q[proc_idx_s1]) begin
						res_rvalid_q <= 1'b1;
						res_rmsg_q   <= rd_msg_s1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_code_q  <= res_code_q;
						m_data_q  <= {5'd0, res_rmsg_q, res_rvalid_q, cnt_ext[3:0]};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_code_q;

	a_idle_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !rd_vld_s1)
		else $error("slot read still in flight while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PTR_W'(SLOTS))
		else $error("active count exceeds the table size");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_axis_tvalid && s_axis_tready))
		else $error("finished result not presented");

	a_tick_compacts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_keep |-> (dst_q <= PTR_W'(proc_idx_s1)))
		else $error("tick compaction writes ahead of the slot being read");

endmodule
